@@ hw/rtl/csb_pkg.sv @@
`default_nettype none

package csb_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_SIZE      = 3'd0,
        REG_FRAME_STRIDE    = 3'd1,
        REG_SPRITE_SIZE     = 3'd2,
        REG_SPRITE_POSITION = 3'd3,
        REG_CLIP_ORIGIN     = 3'd4,
        REG_CLIP_SIZE       = 3'd5,
        REG_BLIT_MODE       = 3'd6
    } cfg_reg_t;

    // blit_mode bits
    localparam int MODE_W           = 4;
    localparam int MODE_TRANSPARENT = 0;
    localparam int MODE_MIRROR_X    = 1;
    localparam int MODE_MIRROR_Y    = 2;
    localparam int MODE_CLIP        = 3;

    localparam int STRIDE_W = 12;
    localparam int EXT_W    = 16;   // one half of a packed size or position
    localparam int PIXEL_W  = 8;
    localparam int WADDR_W  = 24;

    // signed destination coordinate: 16-bit position plus up to 16-bit offset
    localparam int POS_W  = EXT_W + 2;
    // non-negative destination coordinate
    localparam int COORD_W = POS_W - 1;
    // row * stride + column
    localparam int PROD_W = COORD_W + STRIDE_W + 1;

    typedef struct packed {
        logic                 err;
        logic                 vis;
        logic                 last;
        logic [PIXEL_W-1:0]   pixel;
        logic [COORD_W-1:0]   addr_x;
        logic [COORD_W-1:0]   addr_y;
    } stage_t;

endpackage

`default_nettype wire

@@ hw/rtl/clipped_sprite_blitter_top.sv @@
`default_nettype none

// Sprite blitter with color key and clipping. Sprite pixels (palette
// indices) stream in on the s_ channel in raster order; every pixel gives
// exactly one result on the m_ channel carrying a write enable, the linear
// framebuffer address (row * stride + column, wrapped to ADDR_BITS) and the
// pixel itself, with last_pixel marking the final pixel of the sprite.
// Horizontal and vertical mirroring, an optional clip rectangle and
// transparent key 0 are selected by blit_mode; framebuffer bounds always
// apply. An invalid configuration (zero sizes, stride below frame width,
// sprite larger than MAX_EXTENT) flags config_error, suppresses the write and
// restarts the sprite. Throughput is one pixel per clock unless m_ready is
// low; the first stage walks the source counters and does the clip compares,
// the second does the row * stride multiply-add into the output register.
// Configuration registers are written through the cfg_ port, which is
// always ready; write them only while no pixel is in flight.
module clipped_sprite_blitter_top #(
    parameter int MAX_EXTENT = 4095,
    parameter int ADDR_BITS  = 24
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [csb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csb_pkg::CFG_DATA_W-1:0] cfg_data,

    // sprite pixel input
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [csb_pkg::PIXEL_W-1:0]    s_source_pixel,

    // framebuffer write results
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_write_enable,
    output logic [csb_pkg::WADDR_W-1:0]         m_write_address,
    output logic [csb_pkg::PIXEL_W-1:0]         m_write_pixel,
    output logic                                m_last_pixel,
    output logic                                m_config_error
);

    import csb_pkg::*;

    // source counters only ever hold values below MAX_EXTENT
    localparam int CNT_W = $clog2(MAX_EXTENT);
    localparam logic [EXT_W-1:0] MAX_EXT_V = EXT_W'(MAX_EXTENT);
    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] frame_size_reg;
    logic [STRIDE_W-1:0]   frame_stride_reg;
    logic [CFG_DATA_W-1:0] sprite_size_reg;
    logic [CFG_DATA_W-1:0] sprite_position_reg;
    logic [CFG_DATA_W-1:0] clip_origin_reg;
    logic [CFG_DATA_W-1:0] clip_size_reg;
    logic [MODE_W-1:0]     blit_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_size_reg      <= '0;
            frame_stride_reg    <= '0;
            sprite_size_reg     <= '0;
            sprite_position_reg <= '0;
            clip_origin_reg     <= '0;
            clip_size_reg       <= '0;
            blit_mode_reg       <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_SIZE:      frame_size_reg      <= cfg_data;
                REG_FRAME_STRIDE:    frame_stride_reg    <= cfg_data[STRIDE_W-1:0];
                REG_SPRITE_SIZE:     sprite_size_reg     <= cfg_data;
                REG_SPRITE_POSITION: sprite_position_reg <= cfg_data;
                REG_CLIP_ORIGIN:     clip_origin_reg     <= cfg_data;
                REG_CLIP_SIZE:       clip_size_reg       <= cfg_data;
                REG_BLIT_MODE:       blit_mode_reg       <= cfg_data[MODE_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake: stage 1 register, then the output register
    // ------------------------------------------------------------------
    logic   st1_valid_reg;
    stage_t st1_reg;
    logic   out_advance;
    logic   st1_advance;
    logic   in_xfer;

    assign out_advance = !m_valid || m_ready;
    assign st1_advance = out_advance;
    assign s_ready     = !st1_valid_reg || st1_advance;
    assign in_xfer     = s_valid && s_ready;

    // ------------------------------------------------------------------
    // stage 1: source counters, destination position, visibility
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] col_reg, row_reg;
    logic [CNT_W-1:0] col_next, row_next;

    logic [EXT_W-1:0] fw, fh, sw, sh;
    logic             err_c;
    logic             out_of_range;
    logic [CNT_W-1:0] col_eff, row_eff;
    logic [EXT_W-1:0] sc, sr;
    logic             col_at_end, row_at_end, last_c;

    logic signed [POS_W-1:0] dx, dy;
    logic signed [POS_W-1:0] clip_x0, clip_y0, clip_x1, clip_y1;
    logic                    in_frame, in_clip, keyed, vis_c;
    stage_t                  st1_next;

    always_comb begin
        fw = frame_size_reg[EXT_W-1:0];
        fh = frame_size_reg[2*EXT_W-1:EXT_W];
        sw = sprite_size_reg[EXT_W-1:0];
        sh = sprite_size_reg[2*EXT_W-1:EXT_W];

        err_c = (fw == '0) || (fh == '0) || (sw == '0) || (sh == '0)
             || (EXT_W'(frame_stride_reg) < fw)
             || (sw > MAX_EXT_V) || (sh > MAX_EXT_V);

        // a shrunk sprite restarts the walk at the origin
        out_of_range = (EXT_W'(col_reg) >= sw) || (EXT_W'(row_reg) >= sh);
        col_eff = out_of_range ? '0 : col_reg;
        row_eff = out_of_range ? '0 : row_reg;

        sc = blit_mode_reg[MODE_MIRROR_X] ? (sw - EXT_W'(1) - EXT_W'(col_eff))
                                          : EXT_W'(col_eff);
        sr = blit_mode_reg[MODE_MIRROR_Y] ? (sh - EXT_W'(1) - EXT_W'(row_eff))
                                          : EXT_W'(row_eff);

        dx = POS_W'($signed(sprite_position_reg[EXT_W-1:0])) + $signed(POS_W'(sc));
        dy = POS_W'($signed(sprite_position_reg[2*EXT_W-1:EXT_W]))
           + $signed(POS_W'(sr));

        in_frame = !dx[POS_W-1] && !dy[POS_W-1]
                && (dx < $signed(POS_W'(fw))) && (dy < $signed(POS_W'(fh)));

        clip_x0 = POS_W'($signed(clip_origin_reg[EXT_W-1:0]));
        clip_y0 = POS_W'($signed(clip_origin_reg[2*EXT_W-1:EXT_W]));
        clip_x1 = clip_x0 + $signed(POS_W'(clip_size_reg[EXT_W-1:0]));
        clip_y1 = clip_y0 + $signed(POS_W'(clip_size_reg[2*EXT_W-1:EXT_W]));
        in_clip = !blit_mode_reg[MODE_CLIP]
               || ((dx >= clip_x0) && (dx < clip_x1) && (dy >= clip_y0) && (dy < clip_y1));

        // color key: index zero is see-through in transparent mode
        keyed = blit_mode_reg[MODE_TRANSPARENT] && (s_source_pixel == '0);
        vis_c = in_frame && in_clip && !keyed;

        col_at_end = (EXT_W'(col_eff) == sw - EXT_W'(1));
        row_at_end = (EXT_W'(row_eff) == sh - EXT_W'(1));
        last_c     = col_at_end && row_at_end;

        if (err_c || last_c) begin
            col_next = '0;
            row_next = '0;
        end else if (col_at_end) begin
            col_next = '0;
            row_next = row_eff + CNT_W'(1);
        end else begin
            col_next = col_eff + CNT_W'(1);
            row_next = row_eff;
        end

        st1_next.err   = err_c;
        st1_next.vis   = vis_c && !err_c;
        st1_next.last  = last_c && !err_c;
        st1_next.pixel = s_source_pixel;
        // left of or above the framebuffer the address collapses to zero
        if (!dx[POS_W-1] && !dy[POS_W-1]) begin
            st1_next.addr_x = dx[COORD_W-1:0];
            st1_next.addr_y = dy[COORD_W-1:0];
        end else begin
            st1_next.addr_x = '0;
            st1_next.addr_y = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s_ready) begin
                st1_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            st1_reg <= st1_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: row * stride + column into the output register
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] addr_full;
    logic [31:0]       addr_wrapped;

    always_comb begin
        addr_full = PROD_W'(st1_reg.addr_y) * PROD_W'(frame_stride_reg)
                  + PROD_W'(st1_reg.addr_x);
        addr_wrapped = 32'(addr_full) & ADDR_MASK;
    end

    logic                 m_valid_reg;
    logic                 m_write_enable_reg;
    logic [WADDR_W-1:0]   m_write_address_reg;
    logic [PIXEL_W-1:0]   m_write_pixel_reg;
    logic                 m_last_pixel_reg;
    logic                 m_config_error_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_advance) begin
            m_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_advance && st1_valid_reg) begin
            m_write_enable_reg <= st1_reg.vis;
            m_last_pixel_reg   <= st1_reg.last;
            m_config_error_reg <= st1_reg.err;
            // invalid configuration zeroes the payload
            if (st1_reg.err) begin
                m_write_address_reg <= '0;
                m_write_pixel_reg   <= '0;
            end else begin
                m_write_address_reg <= addr_wrapped[WADDR_W-1:0];
                m_write_pixel_reg   <= st1_reg.pixel;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_enable  = m_write_enable_reg;
    assign m_write_address = m_write_address_reg;
    assign m_write_pixel   = m_write_pixel_reg;
    assign m_last_pixel    = m_last_pixel_reg;
    assign m_config_error  = m_config_error_reg;

endmodule

`default_nettype wire
